@@ hdl/dsed_pkg.sv @@
`timescale 1ns / 1ps
package dsed_pkg;

  localparam int CNT_W = 9;

  localparam logic [CNT_W-1:0] MIN_FRAME_LEN = 9'd3;
  localparam logic [CNT_W-1:0] LEN_OVERHEAD  = 9'd3;

  localparam logic [1:0] CHK_OK    = 2'd0;
  localparam logic [1:0] CHK_SHORT = 2'd1;
  localparam logic [1:0] CHK_LEN   = 2'd2;
  localparam logic [1:0] CHK_SUM   = 2'd3;

  localparam logic EV_CONTENT = 1'b0;
  localparam logic EV_REJECT  = 1'b1;

  localparam logic [1:0] CFG_MAX_FRAME = 2'd0;
  localparam logic [1:0] CFG_ESCAPE    = 2'd1;
  localparam logic [1:0] CFG_START     = 2'd2;
  localparam logic [1:0] CFG_END       = 2'd3;

  typedef enum logic [3:0] {
    ST_WAIT      = 4'b0001,
    ST_WAIT_ESC  = 4'b0010,
    ST_FRAME     = 4'b0100,
    ST_FRAME_ESC = 4'b1000
  } parse_state_t;

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_FETCH = 3'b010,
    B_LOAD  = 3'b100
  } back_state_t;

  typedef struct packed {
    logic [6:0] max_frame_bytes;
    logic [7:0] escape_code;
    logic [7:0] start_code;
    logic [7:0] end_code;
  } cfg_t;

  typedef struct packed {
    logic             rej;
    logic [CNT_W-1:0] cnt;
    logic [1:0]       chk;
  } cmd_t;

endpackage

@@ hdl/dle_stx_etx_deframer_with_checksum_core.sv @@
`timescale 1ns / 1ps
// DLE/STX/ETX deframer with frame check. The parser takes one raw byte per
// cycle while full is low and writes payload bytes into a MAX_FRAME-entry
// frame memory. Rejects and frame-end commands pass through a two-entry
// command queue to the drain side, which moves one item per cycle for rejects
// and empty frames while the output is free, and for a completed frame moves
// each payload byte through a memory read, then the output register. From the
// closing escape/end pair until the last byte of that frame is in the output
// register, full stays high and holds the input, output backpressure included.
module dle_stx_etx_deframer_with_checksum_core #(
  parameter int MAX_FRAME = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_rx_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic       out_event_kind,
  output logic       out_has_data,
  output logic [7:0] out_payload_byte,
  output logic       out_last_of_frame,
  output logic [1:0] out_frame_check,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int AW = $clog2(MAX_FRAME);

  dsed_pkg::cfg_t cfg_r, cfg_nxt;
  logic           frame_busy_r, frame_busy_nxt;
  logic           accept;
  logic           cmd_push;
  dsed_pkg::cmd_t cmd_in;
  dsed_pkg::cmd_t cmd_head;
  logic           fifo_full;
  logic           cmd_valid;
  logic           cmd_pop;
  logic           frame_done;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        dsed_pkg::CFG_MAX_FRAME: cfg_nxt.max_frame_bytes = cfg_data[6:0];
        dsed_pkg::CFG_ESCAPE:    cfg_nxt.escape_code     = cfg_data;
        dsed_pkg::CFG_START:     cfg_nxt.start_code      = cfg_data;
        dsed_pkg::CFG_END:       cfg_nxt.end_code        = cfg_data;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  assign in_full = fifo_full || frame_busy_r;
  assign accept  = in_push && !in_full;

  always_comb begin
    frame_busy_nxt = frame_busy_r;
    if (cmd_push && !cmd_in.rej) frame_busy_nxt = 1'b1;
    else if (frame_done) frame_busy_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_frame_bytes <= 7'd64;
      cfg_r.escape_code     <= 8'd16;
      cfg_r.start_code      <= 8'd2;
      cfg_r.end_code        <= 8'd3;
      frame_busy_r          <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      frame_busy_r <= frame_busy_nxt;
    end
  end

  dsed_front #(.MAX_FRAME(MAX_FRAME)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .cfg       (cfg_r),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  dsed_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .pop      (cmd_pop),
    .full     (fifo_full),
    .valid    (cmd_valid),
    .head     (cmd_head)
  );

  dsed_back #(.MAX_FRAME(MAX_FRAME)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .mem_we            (mem_we),
    .mem_waddr         (mem_waddr),
    .mem_wdata         (mem_wdata),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd_head),
    .cmd_pop           (cmd_pop),
    .frame_done        (frame_done),
    .out_pop           (out_pop),
    .out_empty         (out_empty),
    .out_event_kind    (out_event_kind),
    .out_has_data      (out_has_data),
    .out_payload_byte  (out_payload_byte),
    .out_last_of_frame (out_last_of_frame),
    .out_frame_check   (out_frame_check)
  );

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_push |-> !fifo_full)
    else $error("command pushed into full queue");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |-> frame_busy_r)
    else $error("frame drain finished with no frame outstanding");

  a_no_write_drain: assert property (@(posedge clk) disable iff (!rst_n)
    frame_busy_r |-> !mem_we)
    else $error("frame memory written while a frame drains");

  a_reject_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_event_kind) |-> (out_last_of_frame && !out_has_data))
    else $error("malformed reject item");

endmodule

@@ hdl/dsed_front.sv @@
`timescale 1ns / 1ps
module dsed_front #(
  parameter int MAX_FRAME = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [7:0]                   rx_byte,
  input  dsed_pkg::cfg_t               cfg,
  output logic                         cmd_push,
  output dsed_pkg::cmd_t               cmd,
  output logic                         mem_we,
  output logic [$clog2(MAX_FRAME)-1:0] mem_waddr,
  output logic [7:0]                   mem_wdata
);

  localparam int AW = $clog2(MAX_FRAME);
  localparam int CW = $clog2(MAX_FRAME + 1);

  dsed_pkg::parse_state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    byte1_r, byte1_nxt;

  logic [dsed_pkg::CNT_W-1:0] cnt_ext;
  logic [dsed_pkg::CNT_W-1:0] cfg_lim;
  logic [dsed_pkg::CNT_W-1:0] lim;
  logic                       at_limit;
  logic [1:0]                 chk;
  logic                       do_store;

  assign cnt_ext  = dsed_pkg::CNT_W'(cnt_r);
  assign cfg_lim  = dsed_pkg::CNT_W'(cfg.max_frame_bytes);
  assign lim      = (cfg_lim < dsed_pkg::CNT_W'(MAX_FRAME)) ? cfg_lim
                                                            : dsed_pkg::CNT_W'(MAX_FRAME);
  assign at_limit = (cnt_ext >= lim);

  always_comb begin
    if (cnt_ext < dsed_pkg::MIN_FRAME_LEN) begin
      chk = dsed_pkg::CHK_SHORT;
    end else if (cnt_ext != (dsed_pkg::CNT_W'(byte1_r) + dsed_pkg::LEN_OVERHEAD)) begin
      chk = dsed_pkg::CHK_LEN;
    end else if (sum_r != 8'd0) begin
      chk = dsed_pkg::CHK_SUM;
    end else begin
      chk = dsed_pkg::CHK_OK;
    end
  end

  assign mem_waddr = cnt_r[AW-1:0];
  assign mem_wdata = rx_byte;

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    byte1_nxt = byte1_r;
    cmd_push  = 1'b0;
    cmd       = '0;
    mem_we    = 1'b0;
    do_store  = 1'b0;
    if (accept) begin
      unique case (st_r)
        dsed_pkg::ST_WAIT: begin
          if (rx_byte == cfg.escape_code) st_nxt = dsed_pkg::ST_WAIT_ESC;
        end
        dsed_pkg::ST_WAIT_ESC: begin
          if (rx_byte == cfg.start_code) begin
            cnt_nxt = '0;
            sum_nxt = '0;
            st_nxt  = dsed_pkg::ST_FRAME;
          end else if (rx_byte != cfg.escape_code) begin
            st_nxt = dsed_pkg::ST_WAIT;
          end
        end
        dsed_pkg::ST_FRAME: begin
          if (rx_byte == cfg.escape_code) st_nxt = dsed_pkg::ST_FRAME_ESC;
          else do_store = 1'b1;
        end
        dsed_pkg::ST_FRAME_ESC: begin
          if (rx_byte == cfg.escape_code) begin
            st_nxt   = dsed_pkg::ST_FRAME;
            do_store = 1'b1;
          end else if (rx_byte == cfg.end_code) begin
            cmd_push = 1'b1;
            cmd.rej  = 1'b0;
            cmd.cnt  = cnt_ext;
            cmd.chk  = chk;
            cnt_nxt  = '0;
            sum_nxt  = '0;
            st_nxt   = dsed_pkg::ST_WAIT;
          end else begin
            cmd_push = 1'b1;
            cmd.rej  = 1'b1;
            cnt_nxt  = '0;
            sum_nxt  = '0;
            st_nxt   = (rx_byte == cfg.start_code) ? dsed_pkg::ST_FRAME : dsed_pkg::ST_WAIT;
          end
        end
        default: st_nxt = dsed_pkg::ST_WAIT;
      endcase
      if (do_store) begin
        if (at_limit) begin
          cmd_push = 1'b1;
          cmd.rej  = 1'b1;
          cnt_nxt  = '0;
          sum_nxt  = '0;
          st_nxt   = dsed_pkg::ST_WAIT;
        end else begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
          sum_nxt = sum_r + rx_byte;
          if (cnt_r == CW'(1)) byte1_nxt = rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= dsed_pkg::ST_WAIT;
      cnt_r <= '0;
      sum_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte1_r <= byte1_nxt;
  end

endmodule

@@ hdl/dsed_cmd_fifo.sv @@
`timescale 1ns / 1ps
module dsed_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dsed_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           valid,
  output dsed_pkg::cmd_t head
);

  dsed_pkg::cmd_t ent_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign head    = ent_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wptr_nxt = do_push ? ~wptr_r : wptr_r;
    rptr_nxt = do_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wptr_r] <= push_cmd;
  end

endmodule

@@ hdl/dsed_back.sv @@
`timescale 1ns / 1ps
module dsed_back #(
  parameter int MAX_FRAME = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         mem_we,
  input  logic [$clog2(MAX_FRAME)-1:0] mem_waddr,
  input  logic [7:0]                   mem_wdata,
  input  logic                         cmd_valid,
  input  dsed_pkg::cmd_t               cmd,
  output logic                         cmd_pop,
  output logic                         frame_done,
  input  logic                         out_pop,
  output logic                         out_empty,
  output logic                         out_event_kind,
  output logic                         out_has_data,
  output logic [7:0]                   out_payload_byte,
  output logic                         out_last_of_frame,
  output logic [1:0]                   out_frame_check
);

  localparam int AW = $clog2(MAX_FRAME);
  localparam int CW = $clog2(MAX_FRAME + 1);

  logic [7:0] mem [MAX_FRAME];
  logic [7:0] rd_data_r;

  dsed_pkg::back_state_t st_r, st_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          ov_r, ov_nxt;
  logic          kind_r, kind_nxt;
  logic          has_r, has_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic          last_r, last_nxt;
  logic [1:0]    chk_r, chk_nxt;
  logic          out_free;
  logic          is_last;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[idx_r[AW-1:0]];
  end

  assign out_free = !ov_r || out_pop;
  assign is_last  = ((dsed_pkg::CNT_W'(idx_r) + dsed_pkg::CNT_W'(1)) == cmd.cnt);

  always_comb begin
    st_nxt     = st_r;
    idx_nxt    = idx_r;
    ov_nxt     = ov_r && !out_pop;
    kind_nxt   = kind_r;
    has_nxt    = has_r;
    byte_nxt   = byte_r;
    last_nxt   = last_r;
    chk_nxt    = chk_r;
    cmd_pop    = 1'b0;
    frame_done = 1'b0;
    unique case (st_r)
      dsed_pkg::B_IDLE: begin
        if (cmd_valid && out_free) begin
          if (cmd.rej) begin
            ov_nxt   = 1'b1;
            kind_nxt = dsed_pkg::EV_REJECT;
            has_nxt  = 1'b0;
            byte_nxt = 8'd0;
            last_nxt = 1'b1;
            chk_nxt  = dsed_pkg::CHK_OK;
            cmd_pop  = 1'b1;
          end else if (cmd.cnt == '0) begin
            ov_nxt     = 1'b1;
            kind_nxt   = dsed_pkg::EV_CONTENT;
            has_nxt    = 1'b0;
            byte_nxt   = 8'd0;
            last_nxt   = 1'b1;
            chk_nxt    = cmd.chk;
            cmd_pop    = 1'b1;
            frame_done = 1'b1;
          end else begin
            idx_nxt = '0;
            st_nxt  = dsed_pkg::B_FETCH;
          end
        end
      end
      dsed_pkg::B_FETCH: st_nxt = dsed_pkg::B_LOAD;
      dsed_pkg::B_LOAD: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          kind_nxt = dsed_pkg::EV_CONTENT;
          has_nxt  = 1'b1;
          byte_nxt = rd_data_r;
          last_nxt = is_last;
          chk_nxt  = is_last ? cmd.chk : dsed_pkg::CHK_OK;
          if (is_last) begin
            cmd_pop    = 1'b1;
            frame_done = 1'b1;
            st_nxt     = dsed_pkg::B_IDLE;
          end else begin
            idx_nxt = idx_r + CW'(1);
            st_nxt  = dsed_pkg::B_FETCH;
          end
        end
      end
      default: st_nxt = dsed_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= dsed_pkg::B_IDLE;
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    has_r  <= has_nxt;
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    chk_r  <= chk_nxt;
  end

  assign out_empty         = !ov_r;
  assign out_event_kind    = kind_r;
  assign out_has_data      = has_r;
  assign out_payload_byte  = byte_r;
  assign out_last_of_frame = last_r;
  assign out_frame_check   = chk_r;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

  localparam int MAX_FRAME    = 64;
  localparam int QUIET_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RAW_BYTES    = 210;

  typedef enum logic [1:0] {OP_BYTE, OP_CFG, OP_DRAIN} stim_op_t;

  typedef struct {
    stim_op_t   op;
    logic [1:0] idx;
    logic [7:0] data;
  } stim_t;

  typedef struct {
    logic       kind;
    logic       has;
    logic [7:0] data;
    logic       last_f;
    logic [1:0] chk;
  } deframed_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_rx_byte = 8'd0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic       out_event_kind;
  logic       out_has_data;
  logic [7:0] out_payload_byte;
  logic       out_last_of_frame;
  logic [1:0] out_frame_check;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = dsed_pkg::CFG_MAX_FRAME;
  logic [7:0] cfg_data = 8'd0;

  dle_stx_etx_deframer_with_checksum_core #(
    .MAX_FRAME(MAX_FRAME)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_rx_byte       (in_rx_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_event_kind   (out_event_kind),
    .out_has_data     (out_has_data),
    .out_payload_byte (out_payload_byte),
    .out_last_of_frame(out_last_of_frame),
    .out_frame_check  (out_frame_check),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  stim_t      stim_q[$];
  deframed_t  deframed_q[$];
  logic [7:0] body_q[$];

  // parser model
  dsed_pkg::parse_state_t rx_state = dsed_pkg::ST_WAIT;
  logic [7:0]   frame_mem[$];
  int           frame_len = 0;
  logic [7:0]   frame_sum = 8'd0;
  logic [6:0]   frame_limit = 7'd64;
  logic [7:0]   esc_code = 8'd16;
  logic [7:0]   stx_code = 8'd2;
  logic [7:0]   etx_code = 8'd3;

  // generator view of the settings
  int         g_max = 64;
  logic [7:0] g_esc = 8'd16;
  logic [7:0] g_stx = 8'd2;
  logic [7:0] g_etx = 8'd3;
  int         raw_bytes = 0;

  int   errors = 0;
  int   cycle_count = 0;
  int   accepted_bytes = 0;
  int   checked_items = 0;
  int   frames_seen = 0;
  int   rejects_seen = 0;
  int   cfg_writes = 0;
  int   quiet_cycles = 0;
  logic calm;

  logic       nxt_push;
  logic [7:0] nxt_byte;
  logic       nxt_we;
  logic [1:0] nxt_idx;
  logic [7:0] nxt_data;
  deframed_t  exp_item;

  assign calm = accepted_bytes >= 100 && accepted_bytes < 180;

  task automatic push_item(logic kind, logic has, logic [7:0] data, logic last_f,
                           logic [1:0] chk);
    deframed_t it;
    it.kind   = kind;
    it.has    = has;
    it.data   = data;
    it.last_f = last_f;
    it.chk    = chk;
    deframed_q.insert(deframed_q.size(), it);
  endtask

  task automatic clear_frame();
    frame_len = 0;
    frame_sum = 8'd0;
    frame_mem.delete();
  endtask

  task automatic reject_frame();
    push_item(dsed_pkg::EV_REJECT, 1'b0, 8'd0, 1'b1, dsed_pkg::CHK_OK);
  endtask

  task automatic store_payload(logic [7:0] b);
    int lim;
    lim = (int'(frame_limit) > MAX_FRAME) ? MAX_FRAME : int'(frame_limit);
    if (frame_len >= lim) begin
      clear_frame();
      rx_state = dsed_pkg::ST_WAIT;
      reject_frame();
    end else begin
      frame_mem.insert(frame_mem.size(), b);
      frame_len++;
      frame_sum = frame_sum + b;
    end
  endtask

  task automatic emit_frame();
    logic [1:0] chk;
    if (frame_len < int'(dsed_pkg::MIN_FRAME_LEN)) chk = dsed_pkg::CHK_SHORT;
    else if (frame_len != int'(frame_mem[1]) + int'(dsed_pkg::LEN_OVERHEAD))
      chk = dsed_pkg::CHK_LEN;
    else if (frame_sum != 8'd0) chk = dsed_pkg::CHK_SUM;
    else chk = dsed_pkg::CHK_OK;
    if (frame_len == 0) begin
      push_item(dsed_pkg::EV_CONTENT, 1'b0, 8'd0, 1'b1, chk);
    end else begin
      for (int i = 0; i < frame_len; i++) begin
        push_item(dsed_pkg::EV_CONTENT, 1'b1, frame_mem[i], i == frame_len - 1,
                  (i == frame_len - 1) ? chk : dsed_pkg::CHK_OK);
      end
    end
  endtask

  task automatic deframe_byte(logic [7:0] b);
    case (rx_state)
      dsed_pkg::ST_WAIT: begin
        if (b == esc_code) rx_state = dsed_pkg::ST_WAIT_ESC;
      end
      dsed_pkg::ST_WAIT_ESC: begin
        if (b == stx_code) begin
          clear_frame();
          rx_state = dsed_pkg::ST_FRAME;
        end else if (b != esc_code) begin
          rx_state = dsed_pkg::ST_WAIT;
        end
      end
      dsed_pkg::ST_FRAME: begin
        if (b == esc_code) rx_state = dsed_pkg::ST_FRAME_ESC;
        else store_payload(b);
      end
      default: begin
        if (b == esc_code) begin
          rx_state = dsed_pkg::ST_FRAME;
          store_payload(b);
        end else if (b == etx_code) begin
          emit_frame();
          clear_frame();
          rx_state = dsed_pkg::ST_WAIT;
        end else if (b == stx_code) begin
          clear_frame();
          rx_state = dsed_pkg::ST_FRAME;
          reject_frame();
        end else begin
          clear_frame();
          rx_state = dsed_pkg::ST_WAIT;
          reject_frame();
        end
      end
    endcase
  endtask

  task automatic apply_cfg(logic [1:0] idx, logic [7:0] data);
    case (idx)
      dsed_pkg::CFG_MAX_FRAME: frame_limit = data[6:0];
      dsed_pkg::CFG_ESCAPE:    esc_code = data;
      dsed_pkg::CFG_START:     stx_code = data;
      dsed_pkg::CFG_END:       etx_code = data;
      default: ;
    endcase
  endtask

  // stimulus building
  task automatic add_stim(stim_op_t op, logic [1:0] idx, logic [7:0] data);
    stim_t s;
    s.op   = op;
    s.idx  = idx;
    s.data = data;
    stim_q.insert(stim_q.size(), s);
  endtask

  task automatic add_body_byte(logic [7:0] b);
    body_q.insert(body_q.size(), b);
  endtask

  task automatic put_raw(logic [7:0] b);
    add_stim(OP_BYTE, dsed_pkg::CFG_MAX_FRAME, b);
    raw_bytes++;
  endtask

  task automatic put_noise(logic [7:0] b);
    add_stim(OP_BYTE, dsed_pkg::CFG_MAX_FRAME, b);
  endtask

  task automatic put_cfg(logic [1:0] idx, logic [7:0] data);
    add_stim(OP_CFG, idx, data);
    case (idx)
      dsed_pkg::CFG_MAX_FRAME: g_max = int'(data[6:0]);
      dsed_pkg::CFG_ESCAPE:    g_esc = data;
      dsed_pkg::CFG_START:     g_stx = data;
      dsed_pkg::CFG_END:       g_etx = data;
      default: ;
    endcase
  endtask

  task automatic put_drain();
    add_stim(OP_DRAIN, dsed_pkg::CFG_MAX_FRAME, 8'd0);
  endtask

  task automatic put_open();
    put_raw(g_esc);
    put_raw(g_stx);
  endtask

  task automatic put_close();
    put_raw(g_esc);
    put_raw(g_etx);
  endtask

  task automatic put_body();
    foreach (body_q[i]) begin
      if (body_q[i] == g_esc) put_raw(g_esc);
      put_raw(body_q[i]);
    end
  endtask

  task automatic put_frame();
    put_open();
    put_body();
    put_close();
  endtask

  // flaw: 0 good, 1 bad sum, 2 bad length
  task automatic make_body(int len, int flaw);
    logic [7:0] s;
    body_q.delete();
    s = 8'd0;
    for (int i = 0; i < len; i++) add_body_byte(8'($urandom_range(0, 255)));
    if (len >= 3) begin
      body_q[1] = 8'(len - 3);
      if (flaw == 2) body_q[1] = body_q[1] + 8'($urandom_range(1, 200));
      for (int i = 0; i < len - 1; i++) s = s + body_q[i];
      body_q[len-1] = 8'd0 - s;
      if (flaw == 1) body_q[len-1] = body_q[len-1] + 8'($urandom_range(1, 255));
    end
  endtask

  // restore length and checksum after editing a body by hand
  task automatic make_body_fix();
    logic [7:0] s;
    s = 8'd0;
    body_q[1] = 8'(body_q.size() - 3);
    for (int i = 0; i < body_q.size() - 1; i++) s = s + body_q[i];
    body_q[body_q.size()-1] = 8'd0 - s;
  endtask

  task automatic random_setting();
    int r;
    logic [7:0] e, s, t;
    r = $urandom_range(0, 9);
    if (r == 0) put_cfg(dsed_pkg::CFG_MAX_FRAME, 8'd1);
    else if (r == 1) put_cfg(dsed_pkg::CFG_MAX_FRAME, 8'd64);
    else if (r == 2) put_cfg(dsed_pkg::CFG_MAX_FRAME, 8'd127);
    else put_cfg(dsed_pkg::CFG_MAX_FRAME, 8'($urandom_range(3, 12)));
    e = 8'($urandom_range(0, 255));
    do s = 8'($urandom_range(0, 255)); while (s == e);
    do t = 8'($urandom_range(0, 255)); while (t == e || t == s);
    put_cfg(dsed_pkg::CFG_ESCAPE, e);
    put_cfg(dsed_pkg::CFG_START, s);
    put_cfg(dsed_pkg::CFG_END, t);
  endtask

  task automatic build_stimulus();
    int events, pick, flaw, lim;
    logic [7:0] odd;
    events = 0;

    // default codes
    put_noise(8'h00);
    put_noise(8'hFF);
    put_raw(g_esc);
    put_raw(g_esc);
    put_raw(g_stx);
    put_close();
    body_q = '{8'h10, 8'h00, 8'hF0};
    put_frame();
    make_body(4, 0); body_q[0] = 8'hFF; make_body_fix();
    put_frame();
    make_body(5, 1); put_frame();
    make_body(5, 2); put_frame();
    make_body(2, 0); put_frame();
    make_body(1, 0); put_frame();
    // start inside a frame restarts it
    put_open(); put_raw(8'h41); put_open(); make_body(3, 0); put_body(); put_close();
    // bad byte after escape
    put_open(); put_raw(8'h55); put_raw(g_esc); put_raw(8'h77);
    put_noise(g_esc); put_noise(8'h99);
    make_body(3, 0); put_frame();

    put_cfg(dsed_pkg::CFG_MAX_FRAME, 8'd1);
    make_body(1, 0); put_frame();
    make_body(2, 0); put_frame();
    put_cfg(dsed_pkg::CFG_MAX_FRAME, 8'd0);
    make_body(1, 0); put_frame();
    make_body(0, 0); put_frame();
    put_cfg(dsed_pkg::CFG_MAX_FRAME, 8'd127);
    make_body(65, 0); put_frame();
    put_cfg(dsed_pkg::CFG_MAX_FRAME, 8'd64);

    // colliding codes
    put_cfg(dsed_pkg::CFG_ESCAPE, 8'h00);
    put_cfg(dsed_pkg::CFG_START, 8'h00);
    put_cfg(dsed_pkg::CFG_END, 8'hFF);
    body_q = '{8'h00, 8'h00, 8'h00};
    put_frame();
    put_open(); put_raw(8'h12); put_raw(g_esc); put_raw(8'h34);
    put_cfg(dsed_pkg::CFG_ESCAPE, 8'hFF);
    put_cfg(dsed_pkg::CFG_START, 8'h80);
    put_cfg(dsed_pkg::CFG_END, 8'h80);
    make_body(4, 0); put_frame();
    put_open(); put_raw(8'hFF); put_raw(g_esc); put_raw(8'h01);

    while (raw_bytes < RAW_BYTES) begin
      if (events % 8 == 0) random_setting();
      events++;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        flaw = $urandom_range(0, 3);
        if (flaw == 3) flaw = 0;
        if ($urandom_range(0, 4) == 0) make_body($urandom_range(0, 2), flaw);
        else make_body($urandom_range(3, 10), flaw);
        put_frame();
      end else if (pick < 67) begin
        repeat ($urandom_range(1, 4)) put_noise(8'($urandom_range(0, 255)));
      end else if (pick < 77) begin
        make_body($urandom_range(0, 4), 0);
        put_open(); put_body(); put_open();
        make_body($urandom_range(3, 8), 0);
        put_body(); put_close();
      end else if (pick < 87) begin
        make_body($urandom_range(0, 4), 0);
        do odd = 8'($urandom_range(0, 255));
        while (odd == g_esc || odd == g_stx || odd == g_etx);
        put_open(); put_body(); put_raw(g_esc); put_raw(odd);
      end else if (pick < 95) begin
        lim = (g_max > MAX_FRAME) ? MAX_FRAME : g_max;
        make_body(lim + $urandom_range(1, 2), 0);
        put_frame();
      end else begin
        put_drain();
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      cfg_we <= 1'b0;
      quiet_cycles = 0;
    end else begin
      nxt_push = in_push;
      nxt_byte = in_rx_byte;
      nxt_we = 1'b0;
      nxt_idx = cfg_index;
      nxt_data = cfg_data;
      if (in_push && !in_full) begin
        deframe_byte(in_rx_byte);
        accepted_bytes++;
        nxt_push = 1'b0;
      end
      if (deframed_q.size() == 0 && !nxt_push && !cfg_we) quiet_cycles++;
      else quiet_cycles = 0;
      if (!nxt_push && stim_q.size() != 0) begin
        if (stim_q[0].op == OP_BYTE) begin
          if (calm || $urandom_range(0, 99) >= 15) begin
            nxt_push = 1'b1;
            nxt_byte = stim_q[0].data;
            void'(stim_q.pop_front());
          end
        end else if (quiet_cycles >= QUIET_CYCLES) begin
          if (stim_q[0].op == OP_CFG) begin
            nxt_we = 1'b1;
            nxt_idx = stim_q[0].idx;
            nxt_data = stim_q[0].data;
            apply_cfg(nxt_idx, nxt_data);
            cfg_writes++;
          end
          void'(stim_q.pop_front());
          quiet_cycles = 0;
        end
      end
      in_push <= nxt_push;
      in_rx_byte <= nxt_byte;
      cfg_we <= nxt_we;
      cfg_index <= nxt_idx;
      cfg_data <= nxt_data;
    end
  end

  task automatic check_field(string name, logic [7:0] exp, logic [7:0] got);
    if (got !== exp) begin
      $error("%s: expected %0h, got %0h", name, exp, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (deframed_q.size() == 0) begin
          $error("unexpected item: event_kind %0d payload_byte %0h", out_event_kind,
                 out_payload_byte);
          errors++;
        end else begin
          exp_item = deframed_q.pop_front();
          check_field("event_kind", 8'(exp_item.kind), 8'(out_event_kind));
          check_field("has_data", 8'(exp_item.has), 8'(out_has_data));
          check_field("payload_byte", exp_item.data, out_payload_byte);
          check_field("last_of_frame", 8'(exp_item.last_f), 8'(out_last_of_frame));
          check_field("frame_check", 8'(exp_item.chk), 8'(out_frame_check));
          checked_items++;
          if (exp_item.kind == dsed_pkg::EV_REJECT) rejects_seen++;
          else if (exp_item.last_f) frames_seen++;
        end
      end
      out_pop <= calm || $urandom_range(0, 99) >= 15;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (stim_q.size() != 0 || in_push) @(posedge clk);
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("tb_top: %0d raw bytes in, %0d items checked: %0d frames closed, %0d rejects",
             accepted_bytes, checked_items, frames_seen, rejects_seen);
    $display("tb_top: %0d register writes incl. limits 0/1/64/127 and colliding codes",
             cfg_writes);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ dle_stx_etx_deframer_with_checksum_core.f @@
hdl/dsed_pkg.sv
hdl/dsed_front.sv
hdl/dsed_cmd_fifo.sv
hdl/dsed_back.sv
hdl/dle_stx_etx_deframer_with_checksum_core.sv
tb/tb_top.sv
